// File: sv/stun_binding_response_parser_core_macros.svh
// assertion macros for the stun binding response parser
// expects clk and rst_n in the scope of each use
`ifndef STUN_BINDING_RESPONSE_PARSER_CORE_MACROS_SVH
`define STUN_BINDING_RESPONSE_PARSER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define STUNBR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define STUNBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/stunbr_pkg.sv
// shared types and constants of the stun binding response parser
// no dependencies
`timescale 1ns / 1ps

package stunbr_pkg;

  localparam logic [31:0] MAGIC_COOKIE      = 32'h2112_a442;
  localparam logic [15:0] MSG_BIND_SUCCESS  = 16'h0101;
  localparam logic [15:0] ATTR_MAPPED       = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED   = 16'h0020;
  localparam logic [15:0] ATTR_XOR_MAPPED_B = 16'h8020;
  localparam logic [7:0]  TYPE_TOP_MASK     = 8'hc0;
  localparam logic [15:0] XOR_PORT_KEY      = 16'h2112;
  localparam logic [7:0]  FAM_IPV4          = 8'h01;
  localparam logic [7:0]  FAM_IPV6          = 8'h02;
  localparam logic [16:0] HDR_LEN           = 17'd20;
  localparam logic [16:0] COUNT_MAX         = 17'h1ffff;
  localparam logic [16:0] PADDED_MAX        = 17'd65528;
  localparam int          OUT_DATA_W        = 240;
  localparam int          OUT_USER_W        = 2;

  // one byte handed to the parse logic
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } byte_step_t;

  typedef struct packed {
    logic        in_body;
    logic        hdr_ok;
    logic [31:0] txid_hi;
    logic [63:0] txid_lo;
  } hdr_info_t;

  typedef struct packed {
    logic         found;
    logic         is_v6;
    logic [15:0]  port;
    logic [127:0] addr;
  } addr_sel_t;

  typedef struct packed {
    addr_sel_t xor_sel;
    addr_sel_t fb_sel;
  } walk_info_t;

endpackage

// File: sv/stun_binding_response_parser_core.sv
// stun binding response parser, top level with input register and flow control
// depends on stunbr_pkg, stunbr_hdr, stunbr_walk, stunbr_out and the macro header
`timescale 1ns / 1ps
// usage:
// in_* carries one udp payload byte per item, in_tlast on the final byte of
// the datagram. out_* gives one result item per datagram, carrying the mapped
// address (xor form preferred, plain form as fallback) and the transaction id,
// or status 1 with all other fields zero.
// an input byte is registered on acceptance and parsed from the input register, so
// out_tvalid rises once the final byte has moved from the input register into
// the result register, where the result waits to be taken.
// throughput is one byte per cycle, set by the single parse stage between the
// input register and the result register.
// while a result waits on out_tready, non-final bytes keep flowing; only a
// final byte waits in the input register until the result register is free.
// reset clears the input register, the result valid and all per-datagram
// counters and flags; the parser is then at the start of a datagram.
`include "stun_binding_response_parser_core_macros.svh"

module stun_binding_response_parser_core
  import stunbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // port, addr_high, addr_low, txid_high, txid_low
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser   // status, is_ipv6
);

  logic       s0_valid_r;
  logic       s0_last_r;
  logic [7:0] s0_data_r;
  logic       out_free;
  logic       s0_go;
  byte_step_t step;
  hdr_info_t  hdr_info;
  walk_info_t walk_info;

  assign out_free  = !out_tvalid || out_tready;
  assign s0_go     = s0_valid_r && (!s0_last_r || out_free);
  assign in_tready = !s0_valid_r || s0_go;

  assign step.valid = s0_go;
  assign step.last  = s0_last_r;
  assign step.data  = s0_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_data_r <= in_tdata;
      s0_last_r <= in_tlast;
    end
  end

  stunbr_hdr u_hdr (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .info (hdr_info)
  );

  stunbr_walk u_walk (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .hdr  (hdr_info),
    .info (walk_info)
  );

  stunbr_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s0_go && s0_last_r),
    .hdr      (hdr_info),
    .walk     (walk_info),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .out_data (out_tdata),
    .out_user (out_tuser)
  );

  `STUNBR_ASSERT_SAME(a_fail_zero, out_tvalid && out_tuser[0], out_tdata == '0 && !out_tuser[1], "failed result carries nonzero fields")
  `STUNBR_ASSERT_SAME(a_v4_upper_only, out_tvalid && !out_tuser[0] && !out_tuser[1], out_tdata[143:80] == '0 && out_tdata[47:16] == '0, "ipv4 result has stray address bytes")
  `STUNBR_ASSERT_NEXT(a_last_loads, s0_go && s0_last_r, out_tvalid, "final byte did not produce a result")
  `STUNBR_ASSERT_NEXT(a_no_phantom, !(s0_go && s0_last_r) && out_tvalid && out_tready, !out_tvalid, "result appeared without a final byte")

endmodule

// File: sv/stunbr_hdr.sv
// stun header check, byte counter and transaction id capture
// depends on stunbr_pkg
`timescale 1ns / 1ps

module stunbr_hdr
  import stunbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  byte_step_t step,
  output hdr_info_t  info
);

  logic [16:0] byte_count_r, byte_count_nxt;
  logic        header_error_r, header_error_nxt;
  logic [15:0] header_word_r, header_word_nxt;
  logic [15:0] decl_len_r, decl_len_nxt;
  logic [31:0] txid_hi_r, txid_hi_nxt;
  logic [63:0] txid_lo_r, txid_lo_nxt;
  logic [7:0]  cookie_b;
  logic [16:0] total_len;

  always_comb begin
    byte_count_nxt   = (byte_count_r != COUNT_MAX) ? byte_count_r + 17'd1 : byte_count_r;
    header_error_nxt = header_error_r;
    header_word_nxt  = header_word_r;
    decl_len_nxt     = decl_len_r;
    txid_hi_nxt      = txid_hi_r;
    txid_lo_nxt      = txid_lo_r;
    cookie_b         = MAGIC_COOKIE[{~byte_count_r[1:0], 3'b000} +: 8];
    if (byte_count_r < HDR_LEN) begin
      if (byte_count_r == 17'd0) begin
        header_word_nxt = {step.data, 8'h00};
        if ((step.data & TYPE_TOP_MASK) != 8'h00) header_error_nxt = 1'b1;
      end else if (byte_count_r == 17'd1) begin
        header_word_nxt = {header_word_r[15:8], step.data};
      end else if (byte_count_r == 17'd2) begin
        decl_len_nxt = {step.data, 8'h00};
      end else if (byte_count_r == 17'd3) begin
        decl_len_nxt = {decl_len_r[15:8], step.data};
      end else if (byte_count_r < 17'd8) begin
        if (step.data != cookie_b) header_error_nxt = 1'b1;
      end else if (byte_count_r < 17'd12) begin
        txid_hi_nxt = {txid_hi_r[23:0], step.data};
      end else begin
        txid_lo_nxt = {txid_lo_r[55:0], step.data};
      end
    end
    total_len = HDR_LEN + {1'b0, decl_len_nxt};
  end

  assign info.in_body = (byte_count_r >= HDR_LEN);
  assign info.hdr_ok  = (byte_count_nxt >= HDR_LEN) && !header_error_nxt &&
                        (header_word_nxt == MSG_BIND_SUCCESS) &&
                        (decl_len_nxt[1:0] == 2'b00) && (byte_count_nxt == total_len);
  assign info.txid_hi = txid_hi_nxt;
  assign info.txid_lo = txid_lo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      header_error_r <= 1'b0;
    end else if (step.valid) begin
      byte_count_r   <= step.last ? 17'd0 : byte_count_nxt;
      header_error_r <= step.last ? 1'b0 : header_error_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid) begin
      header_word_r <= header_word_nxt;
      decl_len_r    <= decl_len_nxt;
      txid_hi_r     <= txid_hi_nxt;
      txid_lo_r     <= txid_lo_nxt;
    end
  end

endmodule

// File: sv/stunbr_walk.sv
// attribute walk and mapped address capture
// depends on stunbr_pkg
`timescale 1ns / 1ps

module stunbr_walk
  import stunbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  byte_step_t step,
  input  hdr_info_t  hdr,
  output walk_info_t info
);

  logic [15:0]  pos_r, pos_nxt;
  logic         walk_err_r, walk_err_nxt;
  logic         xor_found_r, xor_found_nxt;
  logic         fb_found_r, fb_found_nxt;
  logic [15:0]  kind_r, kind_nxt;
  logic [15:0]  vlen_r, vlen_nxt;
  logic [7:0]   fam_r, fam_nxt;
  logic [15:0]  cport_r, cport_nxt;
  logic [127:0] caddr_r, caddr_nxt;
  addr_sel_t    best_r, best_nxt;
  addr_sel_t    fb_r, fb_nxt;
  addr_sel_t    dec;
  logic         active;
  logic         finish;
  logic         is_xor;
  logic [16:0]  padded;
  logic [15:0]  k;
  logic         err_end;

  function automatic addr_sel_t decode_addr(input logic xored, input logic [15:0] len,
                                            input logic [7:0] fam, input logic [15:0] port,
                                            input logic [127:0] addr,
                                            input logic [95:0] txid);
    addr_sel_t    d;
    logic         v4;
    logic         v6;
    logic [127:0] key;
    logic [127:0] mask;
    v4      = (fam == FAM_IPV4);
    v6      = (fam == FAM_IPV6);
    d.found = (v4 && len >= 16'd8) || (v6 && len >= 16'd20);
    d.is_v6 = v6;
    d.port  = xored ? (port ^ XOR_PORT_KEY) : port;
    key     = xored ? {MAGIC_COOKIE, txid} : '0;
    mask    = v6 ? '1 : {32'hffff_ffff, 96'h0};
    d.addr  = (addr ^ key) & mask;
    return d;
  endfunction

  always_comb begin
    pos_nxt       = pos_r;
    walk_err_nxt  = walk_err_r;
    xor_found_nxt = xor_found_r;
    fb_found_nxt  = fb_found_r;
    kind_nxt      = kind_r;
    vlen_nxt      = vlen_r;
    fam_nxt       = fam_r;
    cport_nxt     = cport_r;
    caddr_nxt     = caddr_r;
    best_nxt      = best_r;
    fb_nxt        = fb_r;
    finish        = 1'b0;
    padded        = ({1'b0, vlen_r} + 17'd3) & ~17'd3;
    k             = pos_r - 16'd4;
    active        = hdr.in_body && !xor_found_r && !walk_err_r;
    if (active) begin
      if (pos_r < 16'd4) begin
        case (pos_r[1:0])
          2'd0:    kind_nxt = {step.data, 8'h00};
          2'd1:    kind_nxt = {kind_r[15:8], step.data};
          2'd2:    vlen_nxt = {step.data, 8'h00};
          default: vlen_nxt = {vlen_r[15:8], step.data};
        endcase
        if (pos_r[1:0] != 2'd3) begin
          pos_nxt = pos_r + 16'd1;
        end else begin
          padded = ({1'b0, vlen_nxt} + 17'd3) & ~17'd3;
          if (padded > PADDED_MAX) begin
            walk_err_nxt = 1'b1;
          end else if (padded == 17'd0) begin
            finish  = 1'b1;
            pos_nxt = '0;
          end else begin
            pos_nxt = 16'd4;
          end
        end
      end else begin
        if (k < vlen_r) begin
          if (k == 16'd1) fam_nxt = step.data;
          if (k == 16'd2) cport_nxt = {step.data, 8'h00};
          if (k == 16'd3) cport_nxt = {cport_r[15:8], step.data};
          for (int i = 0; i < 16; i++) begin
            if (k == 16'(i + 4)) caddr_nxt[127 - 8 * i -: 8] = step.data;
          end
        end
        if ({1'b0, pos_r} == padded + 17'd3) begin
          finish  = 1'b1;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + 16'd1;
        end
      end
    end
    is_xor = (kind_nxt == ATTR_XOR_MAPPED) || (kind_nxt == ATTR_XOR_MAPPED_B);
    dec    = decode_addr(is_xor, vlen_nxt, fam_nxt, cport_nxt, caddr_nxt,
                         {hdr.txid_hi, hdr.txid_lo});
    if (finish && dec.found) begin
      if (is_xor) begin
        best_nxt      = dec;
        xor_found_nxt = 1'b1;
      end else if (kind_nxt == ATTR_MAPPED && !fb_found_r) begin
        fb_nxt       = dec;
        fb_found_nxt = 1'b1;
      end
    end
    err_end = walk_err_nxt || (!xor_found_nxt && pos_nxt != 16'd0);
  end

  always_comb begin
    info.xor_sel       = best_nxt;
    info.xor_sel.found = xor_found_nxt;
    info.fb_sel        = fb_nxt;
    info.fb_sel.found  = fb_found_nxt && !err_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      walk_err_r  <= 1'b0;
      xor_found_r <= 1'b0;
      fb_found_r  <= 1'b0;
    end else if (step.valid) begin
      pos_r       <= step.last ? 16'd0 : pos_nxt;
      walk_err_r  <= step.last ? 1'b0 : walk_err_nxt;
      xor_found_r <= step.last ? 1'b0 : xor_found_nxt;
      fb_found_r  <= step.last ? 1'b0 : fb_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid) begin
      kind_r  <= kind_nxt;
      vlen_r  <= vlen_nxt;
      fam_r   <= fam_nxt;
      cport_r <= cport_nxt;
      caddr_r <= caddr_nxt;
      best_r  <= best_nxt;
      fb_r    <= fb_nxt;
    end
  end

endmodule

// File: sv/stunbr_out.sv
// result selection and output register
// depends on stunbr_pkg
`timescale 1ns / 1ps

module stunbr_out
  import stunbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  hdr_info_t             hdr,
  input  walk_info_t            walk,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [OUT_USER_W-1:0] out_user
);

  logic                  valid_r;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic [OUT_USER_W-1:0] user_r, user_nxt;
  addr_sel_t             sel;
  logic                  ok;

  always_comb begin
    ok  = 1'b1;
    sel = walk.xor_sel;
    if (hdr.hdr_ok && walk.xor_sel.found) begin
      sel = walk.xor_sel;
    end else if (hdr.hdr_ok && walk.fb_sel.found) begin
      sel = walk.fb_sel;
    end else begin
      ok = 1'b0;
    end
    if (ok) begin
      data_nxt = {hdr.txid_lo, hdr.txid_hi, sel.addr[63:0], sel.addr[127:64], sel.port};
      user_nxt = {sel.is_v6, 1'b0};
    end else begin
      data_nxt = '0;
      user_nxt = {1'b0, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_user  = user_r;

endmodule

// File: tb/sv/stun_binding_response_parser_core_tb.sv
// self-checking testbench for the stun binding response parser core
// drives datagrams byte by byte, predicts each result in place, checks field by field
// depends on stunbr_pkg and stun_binding_response_parser_core
`timescale 1ns / 1ps

module stun_binding_response_parser_core_tb;
  import stunbr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic        status;
    logic        is_v6;
    logic [15:0] port;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] txid_hi;
    logic [63:0] txid_lo;
  } stun_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  byte_item_t   pending_bytes[$];
  stun_result_t expected_results[$];
  logic [7:0]   attr_val[$];
  logic [7:0]   body[$];
  logic [7:0]   pkt[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatches = 0;
  int datagrams_sent = 0;
  int bytes_queued = 0;
  int results_checked = 0;
  int results_found = 0;
  int results_v6 = 0;

  // parser state of the predictor
  logic [16:0]  rx_count;
  logic [15:0]  msg_type;
  logic [15:0]  msg_len;
  logic         hdr_bad;
  logic [31:0]  tid_hi;
  logic [63:0]  tid_lo;
  logic [15:0]  attr_type;
  logic [15:0]  val_len;
  logic [15:0]  attr_pos;
  logic         walk_bad;
  logic [7:0]   fam;
  logic [15:0]  mport;
  logic [127:0] maddr;
  logic         xor_hit;
  logic [15:0]  xor_port;
  logic         xor_v6;
  logic [127:0] xor_addr;
  logic         fb_hit;
  logic [15:0]  fb_port;
  logic         fb_v6;
  logic [127:0] fb_addr;

  stun_binding_response_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d bytes and %0d results outstanding",
             pending_bytes.size(), expected_results.size());
    $display("FAIL");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic clear_parse();
    rx_count = '0; msg_type = '0; msg_len = '0; hdr_bad = 1'b0;
    tid_hi = '0; tid_lo = '0;
    attr_type = '0; val_len = '0; attr_pos = '0; walk_bad = 1'b0;
    fam = '0; mport = '0; maddr = '0;
    xor_hit = 1'b0; xor_port = '0; xor_v6 = 1'b0; xor_addr = '0;
    fb_hit = 1'b0; fb_port = '0; fb_v6 = 1'b0; fb_addr = '0;
  endtask

  function automatic logic [7:0] txid_byte_at(input int j);
    if (j < 4) return tid_hi[8*(3-j) +: 8];
    return tid_lo[8*(11-j) +: 8];
  endfunction

  task automatic decode_mapped(input bit xored, output bit ok, output logic [15:0] p,
                               output logic v6, output logic [127:0] a);
    int ip_len;
    logic [7:0] b;
    ok = 1'b0; p = '0; v6 = 1'b0; a = '0;
    ip_len = (fam == FAM_IPV4) ? 4 : (fam == FAM_IPV6) ? 16 : 0;
    if (val_len >= 4 && ip_len != 0 && val_len >= 4 + ip_len) begin
      ok = 1'b1;
      p = xored ? (mport ^ XOR_PORT_KEY) : mport;
      v6 = (ip_len == 16);
      for (int i = 0; i < ip_len; i++) begin
        b = maddr[127-8*i -: 8];
        if (xored) b = b ^ ((i < 4) ? MAGIC_COOKIE[31-8*i -: 8] : txid_byte_at(i - 4));
        a[127-8*i -: 8] = b;
      end
    end
  endtask

  task automatic close_attr();
    bit ok;
    logic [15:0] p;
    logic v6;
    logic [127:0] a;
    if (attr_type == ATTR_XOR_MAPPED || attr_type == ATTR_XOR_MAPPED_B) begin
      decode_mapped(1'b1, ok, p, v6, a);
      if (ok) begin
        xor_hit = 1'b1; xor_port = p; xor_v6 = v6; xor_addr = a;
      end
    end else if (attr_type == ATTR_MAPPED && !fb_hit) begin
      decode_mapped(1'b0, ok, p, v6, a);
      if (ok) begin
        fb_hit = 1'b1; fb_port = p; fb_v6 = v6; fb_addr = a;
      end
    end
  endtask

  task automatic walk_attr_byte(input logic [7:0] b);
    int p;
    int padded;
    int k;
    p = int'(attr_pos);
    padded = (val_len + 3) & ~3;
    if (!xor_hit && !walk_bad) begin
      if (p < 4) begin
        case (p)
          0: attr_type = {b, 8'h00};
          1: attr_type[7:0] = b;
          2: val_len = {b, 8'h00};
          default: val_len[7:0] = b;
        endcase
        if (p < 3) begin
          attr_pos = 16'(p + 1);
        end else begin
          padded = (val_len + 3) & ~3;
          if (padded > PADDED_MAX) begin
            walk_bad = 1'b1;
          end else if (padded == 0) begin
            close_attr();
            attr_pos = '0;
          end else begin
            attr_pos = 16'd4;
          end
        end
      end else begin
        k = p - 4;
        if (k < val_len) begin
          if (k == 1) fam = b;
          else if (k == 2) mport = {b, 8'h00};
          else if (k == 3) mport[7:0] = b;
          else if (k >= 4 && k < 20) maddr[127-8*(k-4) -: 8] = b;
        end
        if (p == 3 + padded) begin
          close_attr();
          attr_pos = '0;
        end else begin
          attr_pos = 16'(p + 1);
        end
      end
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    int pos;
    bit hdr_ok;
    stun_result_t res;
    pos = int'(rx_count);
    if (rx_count < COUNT_MAX) rx_count = rx_count + 17'd1;
    if (pos < 20) begin
      if (pos == 0) begin
        msg_type = {b, 8'h00};
        if ((b & TYPE_TOP_MASK) != 8'h00) hdr_bad = 1'b1;
      end else if (pos == 1) begin
        msg_type[7:0] = b;
      end else if (pos == 2) begin
        msg_len = {b, 8'h00};
      end else if (pos == 3) begin
        msg_len[7:0] = b;
      end else if (pos < 8) begin
        if (b != MAGIC_COOKIE[31-8*(pos-4) -: 8]) hdr_bad = 1'b1;
      end else if (pos < 12) begin
        tid_hi = {tid_hi[23:0], b};
      end else begin
        tid_lo = {tid_lo[55:0], b};
      end
    end else begin
      walk_attr_byte(b);
    end
    if (last) begin
      if (!xor_hit && attr_pos != 0) walk_bad = 1'b1;
      hdr_ok = rx_count >= HDR_LEN && !hdr_bad && msg_type == MSG_BIND_SUCCESS &&
               msg_len[1:0] == 2'b00 && rx_count == HDR_LEN + {1'b0, msg_len};
      res = '0;
      res.status = 1'b1;
      if (hdr_ok && xor_hit) begin
        res.status = 1'b0; res.is_v6 = xor_v6; res.port = xor_port;
        res.addr_hi = xor_addr[127:64]; res.addr_lo = xor_addr[63:0];
      end else if (hdr_ok && !walk_bad && fb_hit) begin
        res.status = 1'b0; res.is_v6 = fb_v6; res.port = fb_port;
        res.addr_hi = fb_addr[127:64]; res.addr_lo = fb_addr[63:0];
      end
      if (!res.status) begin
        res.txid_hi = tid_hi;
        res.txid_lo = tid_lo;
      end
      expected_results.push_back(res);
      clear_parse();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 200)
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_byte(in_tdata, in_tlast);
        pending_bytes.delete(0);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_bytes[0].data;
          in_tlast <= pending_bytes[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    stun_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[63:0], '0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (!want.status) results_found++;
        if (want.is_v6) results_v6++;
        if (out_tuser[0] !== want.status)
          report_mismatch("status", 64'(out_tuser[0]), 64'(want.status));
        if (out_tuser[1] !== want.is_v6)
          report_mismatch("is_ipv6", 64'(out_tuser[1]), 64'(want.is_v6));
        if (out_tdata[15:0] !== want.port)
          report_mismatch("port", 64'(out_tdata[15:0]), 64'(want.port));
        if (out_tdata[79:16] !== want.addr_hi)
          report_mismatch("addr_high", out_tdata[79:16], want.addr_hi);
        if (out_tdata[143:80] !== want.addr_lo)
          report_mismatch("addr_low", out_tdata[143:80], want.addr_lo);
        if (out_tdata[175:144] !== want.txid_hi)
          report_mismatch("txid_high", 64'(out_tdata[175:144]), 64'(want.txid_hi));
        if (out_tdata[239:176] !== want.txid_lo)
          report_mismatch("txid_low", out_tdata[239:176], want.txid_lo);
      end
    end
  end

  task automatic fill_addr_val(input logic [7:0] family, input int extra);
    int n;
    attr_val.delete();
    attr_val.push_back(rand_byte());
    attr_val.push_back(family);
    attr_val.push_back(rand_byte());
    attr_val.push_back(rand_byte());
    n = (family == FAM_IPV4) ? 4 : (family == FAM_IPV6) ? 16 : $urandom_range(4, 16);
    for (int i = 0; i < n + extra; i++) attr_val.push_back(rand_byte());
  endtask

  // header only when with_value is clear
  task automatic put_attr(input logic [15:0] kind, input int vlen, input bit with_value);
    logic [15:0] len16;
    len16 = 16'(vlen);
    body.push_back(kind[15:8]);
    body.push_back(kind[7:0]);
    body.push_back(len16[15:8]);
    body.push_back(len16[7:0]);
    if (with_value) begin
      for (int i = 0; i < vlen; i++)
        body.push_back((i < attr_val.size()) ? attr_val[i] : rand_byte());
      while (body.size() % 4 != 0) body.push_back(rand_byte());
    end
  endtask

  task automatic put_addr(input logic [15:0] kind, input logic [7:0] family, input int extra);
    fill_addr_val(family, extra);
    put_attr(kind, attr_val.size(), 1'b1);
  endtask

  // negative decl means the true body length
  task automatic wrap(input logic [15:0] mtype, input int decl);
    logic [15:0] dl;
    dl = (decl < 0) ? 16'(body.size()) : 16'(decl);
    pkt.delete();
    pkt.push_back(mtype[15:8]);
    pkt.push_back(mtype[7:0]);
    pkt.push_back(dl[15:8]);
    pkt.push_back(dl[7:0]);
    for (int i = 0; i < 4; i++) pkt.push_back(MAGIC_COOKIE[31-8*i -: 8]);
    for (int i = 0; i < 12; i++) pkt.push_back(rand_byte());
    foreach (body[i]) pkt.push_back(body[i]);
  endtask

  // zero sends the whole datagram, otherwise only its first n bytes
  task automatic send(input int n);
    int cnt;
    cnt = (n <= 0 || n > pkt.size()) ? pkt.size() : n;
    for (int i = 0; i < cnt; i++) pending_bytes.push_back({pkt[i], i == cnt - 1});
    bytes_queued += cnt;
    datagrams_sent++;
  endtask

  task automatic ship();
    wrap(MSG_BIND_SUCCESS, -1);
    send(0);
  endtask

  task automatic random_datagram();
    int nattr;
    int pick;
    int mode;
    int cut;
    int idx;
    logic [15:0] kind;
    logic [15:0] mtype;
    logic [15:0] dl;
    logic [7:0] family;
    body.delete();
    nattr = $urandom_range(0, 3);
    for (int a = 0; a < nattr; a++) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 9) < 8) family = $urandom_range(0, 1) ? FAM_IPV6 : FAM_IPV4;
      else family = rand_byte();
      if (pick < 7) begin
        kind = (pick < 3) ? ATTR_XOR_MAPPED : (pick < 4) ? ATTR_XOR_MAPPED_B : ATTR_MAPPED;
        fill_addr_val(family, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        if ($urandom_range(0, 7) == 0)
          put_attr(kind, $urandom_range(0, attr_val.size() - 1), 1'b1);
        else
          put_attr(kind, attr_val.size(), 1'b1);
      end else begin
        attr_val.delete();
        kind = 16'($urandom_range(0, 65535));
        put_attr(kind, $urandom_range(0, 12), 1'b1);
      end
    end
    mtype = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65535)) : MSG_BIND_SUCCESS;
    wrap(mtype, -1);
    mode = $urandom_range(0, 15);
    cut = 0;
    case (mode)
      0: pkt[0] = pkt[0] | 8'($urandom_range(1, 3) << 6);
      1: begin
        idx = $urandom_range(4, 7);
        pkt[idx] = pkt[idx] ^ 8'($urandom_range(1, 255));
      end
      2: pkt[3] = pkt[3] ^ 8'($urandom_range(1, 3));
      3: pkt[2] = rand_byte();
      4: cut = $urandom_range(1, pkt.size() - 1);
      5: for (int i = 0; i < 4 * $urandom_range(1, 3); i++) pkt.push_back(rand_byte());
      6: begin
        pkt.push_back(rand_byte());
        pkt.push_back(rand_byte());
        pkt.push_back(8'hff);
        pkt.push_back(8'($urandom_range(246, 255)));
      end
      default: ;
    endcase
    if (mode == 5 || mode == 6) begin
      dl = 16'(pkt.size() - 20);
      pkt[2] = dl[15:8];
      pkt[3] = dl[7:0];
    end
    send(cut);
  endtask

  task automatic random_phase(input int min_bytes, input int min_datagrams);
    int start_bytes;
    int n;
    start_bytes = bytes_queued;
    n = 0;
    while (bytes_queued - start_bytes < min_bytes || n < min_datagrams) begin
      random_datagram();
      n++;
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    clear_parse();
    tx_idle_pct = 24;
    rx_idle_pct = 72;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // xor address ipv4, then ipv6 in the comprehension-optional form
    body.delete(); put_addr(ATTR_XOR_MAPPED, FAM_IPV4, 0); ship();
    body.delete(); put_addr(ATTR_XOR_MAPPED_B, FAM_IPV6, 0); ship();
    // plain address as fallback only
    body.delete(); put_addr(ATTR_MAPPED, FAM_IPV4, 0); ship();
    // xor wins over an earlier plain address, with extra value bytes and padding
    body.delete(); put_addr(ATTR_MAPPED, FAM_IPV6, 0); put_addr(ATTR_XOR_MAPPED, FAM_IPV4, 2);
    ship();
    // framing error after the xor address is ignored
    body.delete(); put_addr(ATTR_XOR_MAPPED, FAM_IPV6, 0);
    put_attr(16'($urandom_range(0, 65535)), 16'hffff, 1'b0); ship();
    // datagram ends inside an attribute value, voiding the fallback
    body.delete(); put_addr(ATTR_MAPPED, FAM_IPV4, 0); put_attr(16'h0022, 8, 1'b0); ship();
    // datagram ends inside an attribute header
    body.delete(); put_addr(ATTR_MAPPED, FAM_IPV4, 0); body.push_back(8'h00);
    body.push_back(8'h01); ship();
    // short datagrams
    pkt.delete(); pkt.push_back(rand_byte()); send(0);
    body.delete(); wrap(MSG_BIND_SUCCESS, -1); send(19);
    // bare header, no attributes
    body.delete(); ship();
    // bad top bits, wrong message type, bad cookie
    body.delete(); put_addr(ATTR_XOR_MAPPED, FAM_IPV4, 0); wrap(16'h4101, -1); send(0);
    body.delete(); put_addr(ATTR_XOR_MAPPED, FAM_IPV4, 0); wrap(16'h0111, -1); send(0);
    body.delete(); put_addr(ATTR_XOR_MAPPED, FAM_IPV4, 0); wrap(MSG_BIND_SUCCESS, -1);
    pkt[5] = pkt[5] ^ 8'h01; send(0);
    // length not a multiple of four, and length not matching the byte count
    body.delete(); put_addr(ATTR_XOR_MAPPED, FAM_IPV4, 0); body.push_back(8'h00);
    body.push_back(8'h00); ship();
    body.delete(); put_addr(ATTR_XOR_MAPPED, FAM_IPV4, 0);
    wrap(MSG_BIND_SUCCESS, body.size() + 4); send(0);
    // bad family in xor form, plain address used instead
    body.delete(); put_addr(ATTR_XOR_MAPPED, 8'h03, 0); put_addr(ATTR_MAPPED, FAM_IPV6, 0);
    ship();
    // xor value too short for ipv6, a later xor address wins
    body.delete(); fill_addr_val(FAM_IPV6, 0); put_attr(ATTR_XOR_MAPPED, 19, 1'b1);
    put_addr(ATTR_XOR_MAPPED_B, FAM_IPV4, 0); ship();
    // first plain address wins
    body.delete(); put_addr(ATTR_MAPPED, FAM_IPV4, 0); put_addr(ATTR_MAPPED, FAM_IPV6, 0);
    ship();
    // empty xor attribute
    body.delete(); attr_val.delete(); put_attr(ATTR_XOR_MAPPED, 0, 1'b1);
    put_addr(ATTR_MAPPED, FAM_IPV4, 0); ship();
    // smallest oversized attribute stops the walk
    body.delete(); put_addr(ATTR_MAPPED, FAM_IPV4, 0); put_attr(16'h0030, 65529, 1'b0);
    ship();
    // all ones and all zeros
    pkt.delete(); for (int i = 0; i < 24; i++) pkt.push_back(8'hff); send(0);
    pkt.delete(); for (int i = 0; i < 24; i++) pkt.push_back(8'h00); send(0);
    // largest attribute length that still fits, datagram ends in its value
    body.delete(); put_attr(ATTR_XOR_MAPPED_B, 65528, 1'b0);
    ship();

    random_phase(160, 3);
    drain();

    tx_idle_pct = 72;
    rx_idle_pct = 24;
    random_phase(160, 3);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(160, 3);
    drain();

    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 64'(expected_results.size()), '0);
    $display("sent %0d datagrams in %0d bytes under three idle patterns",
             datagrams_sent, bytes_queued);
    $display("checked %0d results: %0d with an address, %0d of them ipv6, %0d mismatches",
             results_checked, results_found, results_v6, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
